/* rtl/nsts_pkg.sv */
// shared types, constants and helpers for the spoken number token sequencer
// used by every module under rtl; depends on nothing
package nsts_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  localparam logic [13:0] VALUE_MAX     = 14'd9999;
  localparam logic [4:0]  CLIP_DIGIT0   = 5'd5;
  localparam logic [4:0]  CLIP_TEN      = 5'd15;
  localparam logic [4:0]  CLIP_HUNDRED  = 5'd16;
  localparam logic [4:0]  CLIP_THOUSAND = 5'd17;

  typedef logic [3:0] digit_t;

  // one classified number: decimal digits and the highest nonzero place
  typedef struct packed {
    digit_t      d3;
    digit_t      d2;
    digit_t      d1;
    digit_t      d0;
    logic [1:0]  top;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ZERO  = 4'b0010,
    ST_DIGIT = 4'b0100,
    ST_UNIT  = 4'b1000
  } seq_state_t;

  function automatic logic [4:0] unit_clip(input logic [1:0] p);
    logic [4:0] c;
    case (p)
      2'd1:    c = CLIP_TEN;
      2'd2:    c = CLIP_HUNDRED;
      2'd3:    c = CLIP_THOUSAND;
      default: c = CLIP_DIGIT0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/nsts_front.sv */
// front end: saturates the number and splits it into decimal digits over two stages
// depends on nsts_pkg
module nsts_front
  import nsts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [15:0] value,
  output logic        push,
  output entry_t      push_data,
  output logic [1:0]  inflight
);

  logic        val1_r, val1_nxt;
  logic [13:0] v1_r, v1_nxt;
  logic        val2_r, val2_nxt;
  digit_t      d3_r, d3_nxt;
  logic [9:0]  r3_r, r3_nxt;

  digit_t      d2, d1, d0;
  logic [6:0]  r2;

  always_comb begin
    val1_nxt = accept;
    v1_nxt   = (value > 16'd9999) ? VALUE_MAX : value[13:0];
  end

  // thousands digit by comparing against each multiple
  always_comb begin
    d3_nxt = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v1_r >= 14'(k * 1000)) d3_nxt = 4'(k);
    end
    r3_nxt   = 10'(v1_r - 14'(d3_nxt) * 14'd1000);
    val2_nxt = val1_r;
  end

  always_comb begin
    d2 = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r3_r >= 10'(k * 100)) d2 = 4'(k);
    end
    r2 = 7'(r3_r - 10'(d2) * 10'd100);
    d1 = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r2 >= 7'(k * 10)) d1 = 4'(k);
    end
    d0 = 4'(r2 - 7'(d1) * 7'd10);
  end

  always_comb begin
    push_data.d3 = d3_r;
    push_data.d2 = d2;
    push_data.d1 = d1;
    push_data.d0 = d0;
    // zero reads from the units place
    if (d3_r != 4'd0)    push_data.top = 2'd3;
    else if (d2 != 4'd0) push_data.top = 2'd2;
    else if (d1 != 4'd0) push_data.top = 2'd1;
    else                 push_data.top = 2'd0;
  end

  assign push     = val2_r;
  assign inflight = {val1_r & val2_r, val1_r ^ val2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val1_r <= 1'b0;
      val2_r <= 1'b0;
    end else begin
      val1_r <= val1_nxt;
      val2_r <= val2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v1_r <= v1_nxt;
    d3_r <= d3_nxt;
    r3_r <= r3_nxt;
  end

endmodule

/* rtl/nsts_queue.sv */
// short queue of classified numbers between front end and token sequencer
// depends on nsts_pkg
module nsts_queue
  import nsts_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  entry_t         push_data,
  input  logic           pop,
  output entry_t         head,
  output logic           empty,
  output logic [QCW-1:0] count
);

  entry_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* rtl/nsts_back.sv */
// token sequencer: walks one number's places and emits one clip per cycle
// depends on nsts_pkg
module nsts_back
  import nsts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  entry_t     q_head,
  output logic       q_pop,
  output logic       out_strobe,
  output logic [4:0] out_clip_index,
  output logic       out_last
);

  seq_state_t  st_r, st_nxt;
  entry_t      cur_r, cur_nxt;
  logic [1:0]  p_r, p_nxt;
  logic        strobe_r, strobe_nxt;
  logic [4:0]  clip_r, clip_nxt;
  logic        last_r, last_nxt;

  logic [3:0]  nz, mask, lower;
  logic [1:0]  q;
  digit_t      cur_dig;
  logic        done;

  always_comb begin
    nz = {cur_r.d3 != 4'd0, cur_r.d2 != 4'd0, cur_r.d1 != 4'd0, cur_r.d0 != 4'd0};
    case (p_r)
      2'd1:    mask = 4'b0001;
      2'd2:    mask = 4'b0011;
      2'd3:    mask = 4'b0111;
      default: mask = 4'b0000;
    endcase
    lower = nz & mask;
    if (lower[2])      q = 2'd2;
    else if (lower[1]) q = 2'd1;
    else               q = 2'd0;
    case (p_r)
      2'd3:    cur_dig = cur_r.d3;
      2'd2:    cur_dig = cur_r.d2;
      2'd1:    cur_dig = cur_r.d1;
      default: cur_dig = cur_r.d0;
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    p_nxt      = p_r;
    cur_nxt    = cur_r;
    clip_nxt   = CLIP_DIGIT0;
    last_nxt   = 1'b0;
    strobe_nxt = 1'b0;
    case (st_r)
      ST_ZERO: begin
        strobe_nxt = 1'b1;
        st_nxt     = ST_DIGIT;
      end
      ST_DIGIT: begin
        strobe_nxt = 1'b1;
        clip_nxt   = {1'b0, cur_dig} + CLIP_DIGIT0;
        if (p_r == 2'd0) last_nxt = 1'b1;
        else             st_nxt   = ST_UNIT;
      end
      ST_UNIT: begin
        strobe_nxt = 1'b1;
        clip_nxt   = unit_clip(p_r);
        if (lower == 4'b0000) begin
          last_nxt = 1'b1;
        end else begin
          p_nxt = q;
          // a gap of zero places reads as one zero clip
          st_nxt = (q == p_r - 2'd1) ? ST_DIGIT : ST_ZERO;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    done  = (st_r == ST_IDLE) || last_nxt;
    q_pop = done && !q_empty;
    if (done) begin
      if (!q_empty) begin
        cur_nxt = q_head;
        p_nxt   = q_head.top;
        st_nxt  = ST_DIGIT;
      end else begin
        st_nxt = ST_IDLE;
      end
    end
  end

  assign out_strobe     = strobe_r;
  assign out_clip_index = clip_r;
  assign out_last       = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    p_r    <= p_nxt;
    clip_r <= clip_nxt;
    last_r <= last_nxt;
  end

endmodule

/* rtl/number_to_spoken_token_sequence.sv */
// top level of the spoken number token sequencer
// depends on nsts_pkg, nsts_front, nsts_queue and nsts_back
//
// usage:
//   input: drive in_value and raise start; the transaction is taken at a rising
//   edge where start is high and busy is low. values above 9999 read as 9999.
//   output: one clip per cycle on out_clip_index with out_strobe high for that
//   single cycle; out_last marks the final clip of a number. a number gives
//   1 to 7 clips, in order, numbers in the order they were taken.
//   path: with the block empty the first clip passes from the accepting edge
//   through the second front stage, the queue write, the sequencer load and
//   the output register.
//   throughput: the sequencer emits one clip per cycle, with no gap between
//   numbers while the queue already holds the next number.
//   busy is high while the queue and the two front stages together hold
//   4 numbers.
//   reset: synchronous, active low; clears the queue, stages and sequencer.
//   the receiver cannot stall: every strobe is one delivered clip.
module number_to_spoken_token_sequence
  import nsts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_value,
  output logic        out_strobe,
  output logic [4:0]  out_clip_index,
  output logic        out_last
);

  logic           accept;
  logic           push;
  entry_t         push_data;
  logic [1:0]     inflight;
  logic           pop;
  entry_t         head;
  logic           empty;
  logic [QCW-1:0] count;
  logic [3:0]     occupancy;

  assign occupancy = 4'(count) + 4'(inflight);
  assign busy      = (occupancy >= 4'(QDEPTH));
  assign accept    = start && !busy;

  nsts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .value     (in_value),
    .push      (push),
    .push_data (push_data),
    .inflight  (inflight)
  );

  nsts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .count     (count)
  );

  nsts_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (empty),
    .q_head         (head),
    .q_pop          (pop),
    .out_strobe     (out_strobe),
    .out_clip_index (out_clip_index),
    .out_last       (out_last)
  );

endmodule
